// File: rtl/core/ksel_pkg.sv
// ----------------------------------------------------------------------------
// ksel_pkg
// Shared types and constants for the spanning edge select block.
// ----------------------------------------------------------------------------
package ksel_pkg;

    // Node index width and size of the parent table.
    localparam int NODE_W    = 10;
    localparam int MAX_NODES = 1 << NODE_W;

    // Width of the node count register.
    localparam int CNT_W = NODE_W + 1;

    // Edge counter width follows the longest list that is counted.
    localparam int MAX_EDGES = 65536;
    localparam int EDGE_W    = $clog2(MAX_EDGES);

    // Reset value of the node count register.
    localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(MAX_NODES);

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [EDGE_W-1:0] edge_num_t;

    // One result item as handed from the controller to the output register.
    typedef struct packed {
        edge_num_t edge_number;
        logic      selected;
        logic      bad_node;
        logic      last_result;
    } result_t;

    // Write port of the parent memory.
    typedef struct packed {
        logic  en;
        node_t addr;
        node_t data;
    } ram_wr_t;

endpackage

// File: rtl/core/ksel_parent_ram.sv
// ----------------------------------------------------------------------------
// ksel_parent_ram
// Parent table memory: one write port and one read port, registered read
// data with write-through when both ports address the same entry.
// ----------------------------------------------------------------------------
module ksel_parent_ram (
    input  logic              aclk,
    input  ksel_pkg::ram_wr_t wr,
    input  ksel_pkg::node_t   rd_addr,
    output ksel_pkg::node_t   rd_data
);

    ksel_pkg::node_t mem [ksel_pkg::MAX_NODES];
    ksel_pkg::node_t rd_data_reg;

    // Write the entry and register the read; a same-cycle write is forwarded.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (wr.en && (wr.addr == rd_addr)) begin
            rd_data_reg <= wr.data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/ksel_ctrl.sv
// ----------------------------------------------------------------------------
// ksel_ctrl
// Sequencer for one edge: root finds with path compression through the
// parent memory, the merge write, the edge counter and the clearing pass.
// ----------------------------------------------------------------------------
module ksel_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [ksel_pkg::CNT_W-1:0]   node_count,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  ksel_pkg::node_t              in_node_a,
    input  ksel_pkg::node_t              in_node_b,
    input  logic                         in_last,
    output logic                         res_valid,
    input  logic                         res_ready,
    output ksel_pkg::result_t            res,
    output ksel_pkg::ram_wr_t            ram_wr,
    output ksel_pkg::node_t              ram_rd_addr,
    input  ksel_pkg::node_t              ram_rd_data
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND_A,
        ST_COMP_A,
        ST_FIND_B,
        ST_COMP_B,
        ST_MERGE,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    ksel_pkg::node_t     a_reg, a_next;
    ksel_pkg::node_t     b_reg, b_next;
    ksel_pkg::node_t     cur_reg, cur_next;
    ksel_pkg::node_t     root_a_reg, root_a_next;
    ksel_pkg::node_t     root_b_reg, root_b_next;
    ksel_pkg::node_t     clr_idx_reg, clr_idx_next;
    ksel_pkg::edge_num_t edge_cnt_reg, edge_cnt_next;
    logic                last_reg, last_next;
    logic                bad_reg, bad_next;
    logic                sel_reg, sel_next;
    logic                in_bad;

    // An endpoint is bad when it is not below the node count.
    assign in_bad = (ksel_pkg::CNT_W'(in_node_a) >= node_count) ||
                    (ksel_pkg::CNT_W'(in_node_b) >= node_count);

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = '{edge_number: edge_cnt_reg, selected: sel_reg,
                         bad_node: bad_reg, last_result: last_reg};

    // Next state, memory addressing and merge decisions.
    always_comb begin
        state_next    = state_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        cur_next      = cur_reg;
        root_a_next   = root_a_reg;
        root_b_next   = root_b_reg;
        clr_idx_next  = clr_idx_reg;
        edge_cnt_next = edge_cnt_reg;
        last_next     = last_reg;
        bad_next      = bad_reg;
        sel_next      = sel_reg;
        ram_rd_addr   = cur_reg;
        ram_wr        = '{en: 1'b0, addr: cur_reg, data: root_a_reg};

        unique case (state_reg)
            ST_CLEAR: begin
                // Every node becomes its own parent, one entry per cycle.
                ram_wr       = '{en: 1'b1, addr: clr_idx_reg, data: clr_idx_reg};
                clr_idx_next = clr_idx_reg + ksel_pkg::NODE_W'(1);
                if (clr_idx_reg == ksel_pkg::NODE_W'(ksel_pkg::MAX_NODES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                ram_rd_addr = in_node_a;
                if (in_valid) begin
                    a_next    = in_node_a;
                    b_next    = in_node_b;
                    last_next = in_last;
                    bad_next  = in_bad;
                    sel_next  = 1'b0;
                    cur_next  = in_node_a;
                    state_next = in_bad ? ST_DONE : ST_FIND_A;
                end
            end
            ST_FIND_A: begin
                if (ram_rd_data == cur_reg) begin
                    root_a_next = cur_reg;
                    if (a_reg != cur_reg) begin
                        ram_rd_addr = a_reg;
                        cur_next    = a_reg;
                        state_next  = ST_COMP_A;
                    end else begin
                        ram_rd_addr = b_reg;
                        cur_next    = b_reg;
                        state_next  = ST_FIND_B;
                    end
                end else begin
                    ram_rd_addr = ram_rd_data;
                    cur_next    = ram_rd_data;
                end
            end
            ST_COMP_A: begin
                // Point the node at its root and move on to its old parent.
                ram_wr = '{en: 1'b1, addr: cur_reg, data: root_a_reg};
                if (ram_rd_data == root_a_reg) begin
                    ram_rd_addr = b_reg;
                    cur_next    = b_reg;
                    state_next  = ST_FIND_B;
                end else begin
                    ram_rd_addr = ram_rd_data;
                    cur_next    = ram_rd_data;
                end
            end
            ST_FIND_B: begin
                if (ram_rd_data == cur_reg) begin
                    root_b_next = cur_reg;
                    if (b_reg != cur_reg) begin
                        ram_rd_addr = b_reg;
                        cur_next    = b_reg;
                        state_next  = ST_COMP_B;
                    end else begin
                        state_next  = ST_MERGE;
                    end
                end else begin
                    ram_rd_addr = ram_rd_data;
                    cur_next    = ram_rd_data;
                end
            end
            ST_COMP_B: begin
                ram_wr = '{en: 1'b1, addr: cur_reg, data: root_b_reg};
                if (ram_rd_data == root_b_reg) begin
                    state_next = ST_MERGE;
                end else begin
                    ram_rd_addr = ram_rd_data;
                    cur_next    = ram_rd_data;
                end
            end
            ST_MERGE: begin
                // Distinct roots: link the larger root under the smaller one.
                if (root_a_reg != root_b_reg) begin
                    sel_next = 1'b1;
                    if (root_a_reg < root_b_reg) begin
                        ram_wr = '{en: 1'b1, addr: root_b_reg, data: root_a_reg};
                    end else begin
                        ram_wr = '{en: 1'b1, addr: root_a_reg, data: root_b_reg};
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Hand the result over; the final edge starts a clearing pass.
                if (res_ready) begin
                    if (last_reg) begin
                        edge_cnt_next = '0;
                        clr_idx_next  = '0;
                        state_next    = ST_CLEAR;
                    end else begin
                        edge_cnt_next = edge_cnt_reg + ksel_pkg::EDGE_W'(1);
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_idx_reg  <= '0;
            edge_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            edge_cnt_reg <= edge_cnt_next;
        end
        a_reg      <= a_next;
        b_reg      <= b_next;
        cur_reg    <= cur_next;
        root_a_reg <= root_a_next;
        root_b_reg <= root_b_next;
        last_reg   <= last_next;
        bad_reg    <= bad_next;
        sel_reg    <= sel_next;
    end

endmodule

// File: rtl/core/kruskal_spanning_edge_select.sv
// ----------------------------------------------------------------------------
// kruskal_spanning_edge_select
// Edge selection step of a minimum spanning forest over a union-find table.
// ----------------------------------------------------------------------------
// Usage:
// Edges arrive on the s_ channel, already sorted by weight, one per transfer.
// Each edge gives exactly one result transfer on the m_ channel carrying its
// position in the list, whether it joins two components, whether an endpoint
// is out of range, and the end-of-list mark.
// An edge runs the root find of each endpoint, the path compression of each
// walked path and the merge; every parent hop is one read of the parent
// table through its memory port. An edge with an out-of-range endpoint
// skips the root finds and the merge. A result sits in an output register,
// so the next edge is taken while it waits; a stalled receiver holds the
// block once the following edge is done.
// After reset, and after the result of an edge marked last is handed over,
// the block sweeps the parent table with s_ready low, making every node its
// own root again; node_count writes are taken throughout. node_count resets
// to 1024; the user is to write it via cfg_we only while the block is idle,
// which the block itself does not enforce.
// ----------------------------------------------------------------------------
module kruskal_spanning_edge_select (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [ksel_pkg::CNT_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ksel_pkg::NODE_W-1:0]   s_node_a,
    input  logic [ksel_pkg::NODE_W-1:0]   s_node_b,
    input  logic                          s_last_edge,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ksel_pkg::EDGE_W-1:0]   m_edge_number,
    output logic                          m_selected,
    output logic                          m_bad_node,
    output logic                          m_last_result
);

    logic [ksel_pkg::CNT_W-1:0] node_count_reg;
    ksel_pkg::result_t          res;
    ksel_pkg::result_t          out_reg;
    logic                       out_valid_reg;
    logic                       res_valid;
    logic                       res_ready;
    logic                       res_push;
    ksel_pkg::ram_wr_t          ram_wr;
    ksel_pkg::node_t            ram_rd_addr;
    ksel_pkg::node_t            ram_rd_data;

    // Node count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= ksel_pkg::NODE_COUNT_RESET;
        end else if (cfg_we) begin
            node_count_reg <= cfg_wdata;
        end
    end

    ksel_parent_ram u_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    ksel_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .node_count  (node_count_reg),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_node_a   (s_node_a),
        .in_node_b   (s_node_b),
        .in_last     (s_last_edge),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_wr      (ram_wr),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // Output register: free when empty or when its transfer completes now.
    assign res_ready = !out_valid_reg || m_ready;
    assign res_push  = res_valid && res_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_push) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (res_push) begin
            out_reg <= res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_edge_number = out_reg.edge_number;
    assign m_selected    = out_reg.selected;
    assign m_bad_node    = out_reg.bad_node;
    assign m_last_result = out_reg.last_result;

`ifndef SYNTH
    // A result is only pushed into a free output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> (!out_valid_reg || m_ready))
        else $error("result pushed over a pending result");

    // One edge at a time: ready drops right after an input transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second edge accepted while one is in work");

    // The end of a list starts the clearing pass, which blocks input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_push && res.last_result) |=> !s_ready)
        else $error("input accepted before the table was cleared");

    // An edge with a bad endpoint is never selected.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> !(res.selected && res.bad_node))
        else $error("bad edge selected");
`endif

endmodule

// File: bench/spanning_edge_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spanning_edge_checker
// Watches the edge and result channels of the spanning edge select block,
// keeps its own union-find forest to predict the result of every accepted
// edge, and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module spanning_edge_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [ksel_pkg::CNT_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [ksel_pkg::NODE_W-1:0]   s_node_a,
    input  logic [ksel_pkg::NODE_W-1:0]   s_node_b,
    input  logic                          s_last_edge,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [ksel_pkg::EDGE_W-1:0]   m_edge_number,
    input  logic                          m_selected,
    input  logic                          m_bad_node,
    input  logic                          m_last_result,
    output int                            pending,
    output int                            mismatches
);

    import ksel_pkg::*;

    // Predicted forest, list position and node count register.
    node_t              forest [MAX_NODES];
    edge_num_t          edge_pos;
    logic [CNT_W-1:0]   node_count;
    result_t            edge_results_q [$];
    int                 fail_total = 0;

    // Every node becomes a tree of its own.
    function automatic void make_singletons();
        for (int i = 0; i < MAX_NODES; i++) begin
            forest[i] = node_t'(i);
        end
    endfunction

    // Root find that points every node on the walked path straight at the root.
    function automatic node_t component_root(node_t x);
        node_t root;
        node_t nxt;
        root = x;
        while (forest[root] != root) begin
            root = forest[root];
        end
        while (x != root) begin
            nxt       = forest[x];
            forest[x] = root;
            x         = nxt;
        end
        return root;
    endfunction

    // One Kruskal selection step: the larger root is linked under the smaller.
    function automatic result_t select_edge(node_t a, node_t b, logic last);
        result_t          r;
        logic [CNT_W-1:0] lim;
        node_t            ra;
        node_t            rb;
        lim           = (node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count;
        r.edge_number = edge_pos;
        r.selected    = 1'b0;
        r.bad_node    = (CNT_W'(a) >= lim) || (CNT_W'(b) >= lim);
        r.last_result = last;
        if (!r.bad_node) begin
            ra = component_root(a);
            rb = component_root(b);
            if (ra != rb) begin
                r.selected = 1'b1;
                if (ra < rb) begin
                    forest[rb] = ra;
                end else begin
                    forest[ra] = rb;
                end
            end
        end
        edge_pos = edge_pos + 1'b1;
        // The end-of-list mark restarts the forest and the position count.
        if (last) begin
            make_singletons();
            edge_pos = '0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [EDGE_W-1:0] want,
                               input logic [EDGE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            fail_total++;
        end
    endtask

    // Results are checked before new edges are queued, so a stray result
    // can never be matched against an edge taken at the same clock edge.
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            make_singletons();
            edge_pos   = '0;
            node_count = NODE_COUNT_RESET;
            edge_results_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (edge_results_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual edge_number %0d",
                             $time, m_edge_number);
                    fail_total++;
                end else begin
                    want = edge_results_q.pop_front();
                    check_field("edge_number", want.edge_number, m_edge_number);
                    check_field("selected", EDGE_W'(want.selected), EDGE_W'(m_selected));
                    check_field("bad_node", EDGE_W'(want.bad_node), EDGE_W'(m_bad_node));
                    check_field("last_result", EDGE_W'(want.last_result),
                                EDGE_W'(m_last_result));
                end
            end
            if (s_valid && s_ready) begin
                edge_results_q.insert(edge_results_q.size(),
                                      select_edge(s_node_a, s_node_b, s_last_edge));
            end
            // A new node count applies from the next edge on.
            if (cfg_we) begin
                node_count = cfg_wdata;
            end
        end
        pending    <= edge_results_q.size();
        mismatches <= fail_total;
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives edge lists into the spanning edge select block under a range of node
// counts, with random idle bursts on both channels and a long result stall,
// and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb;

    import ksel_pkg::*;

    localparam int RANDOM_EDGES   = 1500;
    localparam int TAIL_EDGES     = 100;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 40;

    logic             aclk          = 1'b0;
    logic             aresetn       = 1'b0;
    logic             cfg_we        = 1'b0;
    logic [CNT_W-1:0] cfg_wdata     = '0;
    logic             s_valid       = 1'b0;
    logic             s_ready;
    node_t            s_node_a      = '0;
    node_t            s_node_b      = '0;
    logic             s_last_edge   = 1'b0;
    logic             m_valid;
    logic             m_ready       = 1'b0;
    edge_num_t        m_edge_number;
    logic             m_selected;
    logic             m_bad_node;
    logic             m_last_result;
    int               pending;
    int               mismatches;

    // Idle controls: the receiver flag and the hold toggle are read by the
    // receiver process, the sender flag only by the stimulus process.
    logic             rx_idle_en    = 1'b1;
    logic             hold_req      = 1'b0;
    bit               tx_idle_en    = 1'b1;

    always #5 aclk = ~aclk;

    kruskal_spanning_edge_select u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_node_a      (s_node_a),
        .s_node_b      (s_node_b),
        .s_last_edge   (s_last_edge),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_edge_number (m_edge_number),
        .m_selected    (m_selected),
        .m_bad_node    (m_bad_node),
        .m_last_result (m_last_result)
    );

    spanning_edge_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_node_a      (s_node_a),
        .s_node_b      (s_node_b),
        .s_last_edge   (s_last_edge),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_edge_number (m_edge_number),
        .m_selected    (m_selected),
        .m_bad_node    (m_bad_node),
        .m_last_result (m_last_result),
        .pending       (pending),
        .mismatches    (mismatches)
    );

    // Offer one edge, after an optional idle burst, and wait for its transfer.
    task automatic send_edge(input node_t a, input node_t b, input logic last);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_node_a    <= a;
        s_node_b    <= b;
        s_last_edge <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait until every predicted result has arrived.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_node_count(input logic [CNT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly small graphs, so that merges and path compression happen often.
    function automatic logic [CNT_W-1:0] pick_node_count();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return CNT_W'(1);
            2:       return '1;
            3:       return CNT_W'($urandom_range(1025, 2046));
            4, 5, 6: return CNT_W'(MAX_NODES);
            7, 8:    return CNT_W'($urandom_range(129, 1023));
            9, 10,
            11, 12:  return CNT_W'($urandom_range(17, 128));
            default: return CNT_W'($urandom_range(2, 16));
        endcase
    endfunction

    // Endpoints are nearly always in range; the rest are any 10-bit index.
    function automatic node_t pick_endpoint(input int limit);
        if (limit > 0 && $urandom_range(0, 15) != 0) begin
            return node_t'($urandom_range(0, limit - 1));
        end
        return node_t'($urandom);
    endfunction

    // Result side: random stalls, plus a long hold each time hold_req toggles.
    initial begin : rx_side
        logic hold_seen;
        hold_seen = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                m_ready  <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin : stimulus
        logic [CNT_W-1:0] node_cnt;
        int               limit;
        int               lists;
        int               len;
        int               sent;
        int               l;
        int               i;
        logic             open_end;
        node_t            a;
        node_t            b;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Full node range: self loop, extreme indices, repeated and closing edges.
        send_edge(0, 0, 1'b0);
        send_edge(10'h3FF, 0, 1'b0);
        send_edge(10'h3FF, 0, 1'b0);
        send_edge(10'h155, 10'h2AA, 1'b0);
        send_edge(10'h2AA, 10'h155, 1'b0);
        send_edge(10'h3FF, 10'h2AA, 1'b1);

        // Four nodes: a cycle-closing edge, an endpoint just out of range and one far out.
        drain_results();
        write_node_count(4);
        send_edge(0, 1, 1'b0);
        send_edge(2, 3, 1'b0);
        send_edge(1, 3, 1'b0);
        send_edge(0, 2, 1'b0);
        send_edge(4, 0, 1'b0);
        send_edge(3, 10'h3FF, 1'b1);

        // Node count changed in the middle of a list; the forest is kept.
        drain_results();
        write_node_count(8);
        send_edge(5, 6, 1'b0);
        send_edge(6, 7, 1'b0);
        drain_results();
        write_node_count(2);
        send_edge(7, 5, 1'b0);
        send_edge(1, 0, 1'b0);
        drain_results();
        write_node_count(8);
        send_edge(5, 7, 1'b0);
        send_edge(4, 5, 1'b1);

        // Zero nodes, a count above the table size, and a single node.
        drain_results();
        write_node_count(0);
        send_edge(0, 0, 1'b1);
        drain_results();
        write_node_count('1);
        send_edge(10'h3FF, 10'h3FE, 1'b0);
        send_edge(10'h3FE, 10'h3FF, 1'b1);
        drain_results();
        write_node_count(1);
        send_edge(0, 0, 1'b0);
        send_edge(0, 1, 1'b1);

        // Long result stall while edges keep coming, so the input backs up.
        drain_results();
        write_node_count(64);
        tx_idle_en = 1'b0;
        hold_req  <= ~hold_req;
        for (i = 0; i < 16; i++) begin
            send_edge(pick_endpoint(64), pick_endpoint(64), 1'b0);
        end
        drain_results();

        // Random phases of edge lists; a phase may end in the middle of a list.
        sent = 0;
        while (sent < RANDOM_EDGES) begin
            drain_results();
            node_cnt = pick_node_count();
            write_node_count(node_cnt);
            limit       = (node_cnt > CNT_W'(MAX_NODES)) ? MAX_NODES : int'(node_cnt);
            tx_idle_en  = ($urandom_range(0, 3) != 0);
            rx_idle_en <= ($urandom_range(0, 3) != 0);
            lists       = $urandom_range(1, 3);
            for (l = 0; l < lists; l++) begin
                if (limit == 0) begin
                    len = $urandom_range(1, 4);
                end else begin
                    len = $urandom_range(1, (limit < 28) ? 2 * limit + 4 : 60);
                end
                open_end = (l == lists - 1) && ($urandom_range(0, 7) == 0);
                for (i = 0; i < len; i++) begin
                    a = pick_endpoint(limit);
                    b = ($urandom_range(0, 15) == 0) ? a : pick_endpoint(limit);
                    send_edge(a, b, (i == len - 1) && !open_end);
                    sent++;
                end
            end
        end

        // One closing list with no idling at all.
        drain_results();
        write_node_count(16);
        tx_idle_en  = 1'b0;
        rx_idle_en <= 1'b0;
        for (i = 0; i < TAIL_EDGES; i++) begin
            send_edge(pick_endpoint(16), pick_endpoint(16), i == TAIL_EDGES - 1);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #200_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/ksel_pkg.sv
rtl/core/ksel_parent_ram.sv
rtl/core/ksel_ctrl.sv
rtl/core/kruskal_spanning_edge_select.sv
bench/spanning_edge_checker.sv
bench/tb.sv
